// ----- sv/cbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg
// Types, codes and helpers shared by the cartridge bank controller modules.
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 1'b1;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // address[15:13] regions
    localparam logic [2:0] REGION_RAM_EN   = 3'd0;
    localparam logic [2:0] REGION_ROM_LOW  = 3'd1;
    localparam logic [2:0] REGION_ROM_HIGH = 3'd2;
    localparam logic [2:0] REGION_MODE     = 3'd3;
    localparam logic [2:0] REGION_RAM      = 3'd5;

    localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
    localparam logic [1:0] RAM_SIZE_2K   = 2'd1;
    localparam logic [1:0] RAM_SIZE_32K  = 2'd3;

    localparam logic [3:0] ENABLE_KEY     = 4'hA;
    localparam logic [6:0] ROM_BANK_RESET = 7'd1;

    localparam int SMALL_RAM_BYTES = 2048;
    localparam int FULL_RAM_BYTES  = 8192;
    localparam int MAX_RAM_BANKS   = 4;

    typedef struct packed {
        logic       refused;
        logic [6:0] bank;
    } cbc_remap_t;

    typedef struct packed {
        logic [6:0] mapped_rom_bank;
        logic [1:0] selected_ram_bank;
        logic       ram_on;
        logic       switch_refused;
        logic       rd_hit;
    } cbc_result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } cbc_ram_req_t;

    // Banks 0x00/0x20/0x40/0x60 map one up; refuse banks beyond the ROM size.
    function automatic cbc_remap_t cbc_remap(input logic [6:0] bank,
                                             input logic [2:0] size_code);
        cbc_remap_t r;
        logic [8:0] count;
        r.bank    = bank + ((bank[4:0] == 5'd0) ? 7'd1 : 7'd0);
        count     = 9'd2 << size_code;
        r.refused = ({2'b00, r.bank} >= count);
        return r;
    endfunction

endpackage

// ----- sv/cartridge_bank_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_controller_unit
// Banked cartridge controller: ROM/RAM bank registers and banked RAM store.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  cfg      | cfg_write             | cfg_index, cfg_data
//  in       | in_valid / in_ready   | func, address, write_data
//  out      | out_valid / out_ready | read_data, mapped_rom_bank,
//           |                       | selected_ram_bank, ram_on, switch_refused
//
//  A transaction passes the input register, then the result register and RAM
//  read data. One transaction per cycle is sustained while out_ready is high;
//  the single RAM port takes at most one access per transaction.
//  A stalled output holds its result; the input register still takes one more
//  transaction. Reset clears bank state and config; RAM contents are not reset.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_unit #(
    parameter int RAM_BANK_BYTES = 8192,
    parameter int RAM_BANKS      = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [15:0]                    address,
    input  logic [7:0]                     write_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     read_data,
    output logic [6:0]                     mapped_rom_bank,
    output logic [1:0]                     selected_ram_bank,
    output logic                           ram_on,
    output logic                           switch_refused
);

    localparam int DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int IDX_W = $clog2(DEPTH);

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_func_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_write_data_reg;
    logic        out_valid_reg, out_valid_next;

    cbc_pkg::cbc_result_t  result;
    cbc_pkg::cbc_result_t  res_reg;
    cbc_pkg::cbc_ram_req_t ram_req;
    logic [IDX_W-1:0]      ram_index;
    logic [7:0]            ram_q;

    logic accept_in;
    logic advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign accept_in = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_func_reg       <= func;
            s1_address_reg    <= address;
            s1_write_data_reg <= write_data;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    cbc_ctrl #(
        .RAM_BANK_BYTES (RAM_BANK_BYTES),
        .RAM_BANKS      (RAM_BANKS),
        .IDX_W          (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .commit     (advance),
        .func       (s1_func_reg),
        .address    (s1_address_reg),
        .write_data (s1_write_data_reg),
        .result     (result),
        .ram_req    (ram_req),
        .ram_index  (ram_index)
    );

    cbc_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .req   (ram_req),
        .index (ram_index),
        .wdata (s1_write_data_reg),
        .rdata (ram_q)
    );

    assign out_valid         = out_valid_reg;
    assign read_data         = res_reg.rd_hit ? ram_q : 8'd0;
    assign mapped_rom_bank   = res_reg.mapped_rom_bank;
    assign selected_ram_bank = res_reg.selected_ram_bank;
    assign ram_on            = res_reg.ram_on;
    assign switch_refused    = res_reg.switch_refused;

endmodule

// ----- sv/cbc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_ram
// Cartridge RAM store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module cbc_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic                  clk,
    input  cbc_pkg::cbc_ram_req_t req,
    input  logic [ADDR_W-1:0]     index,
    input  logic [7:0]            wdata,
    output logic [7:0]            rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[index] <= wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[index];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/cbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_ctrl
// Configuration and bank registers, access decode and RAM slot check.
// ----------------------------------------------------------------------------
module cbc_ctrl #(
    parameter int RAM_BANK_BYTES = 8192,
    parameter int RAM_BANKS      = 4,
    parameter int IDX_W          = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           commit,
    input  logic                           func,
    input  logic [15:0]                    address,
    input  logic [7:0]                     write_data,
    output cbc_pkg::cbc_result_t           result,
    output cbc_pkg::cbc_ram_req_t          ram_req,
    output logic [IDX_W-1:0]               ram_index
);

    localparam logic [13:0] LIM_SMALL = 14'((RAM_BANK_BYTES < cbc_pkg::SMALL_RAM_BYTES) ?
                                            RAM_BANK_BYTES : cbc_pkg::SMALL_RAM_BYTES);
    localparam logic [13:0] LIM_FULL  = 14'((RAM_BANK_BYTES < cbc_pkg::FULL_RAM_BYTES) ?
                                            RAM_BANK_BYTES : cbc_pkg::FULL_RAM_BYTES);
    localparam logic [2:0]  BANKS_BIG = 3'((RAM_BANKS < cbc_pkg::MAX_RAM_BANKS) ?
                                           RAM_BANKS : cbc_pkg::MAX_RAM_BANKS);

    logic [2:0] rom_size_reg;
    logic [1:0] ram_size_reg;
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [6:0] mapped_reg, mapped_next;
    logic       ram_mode_reg, ram_mode_next;
    logic       ram_enable_reg, ram_enable_next;
    logic [1:0] ram_bank_reg, ram_bank_next;

    logic                 do_remap;
    logic [6:0]           rom_cand;
    logic                 refused;
    cbc_pkg::cbc_remap_t  remap;
    logic                 in_ram;
    logic                 slot_ok;
    logic [2:0]           bank_limit;
    logic [13:0]          byte_limit;
    logic [12:0]          offset;
    logic [IDX_W+1:0]     idx_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_reg <= '0;
            ram_size_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cbc_pkg::CFG_ROM_SIZE: rom_size_reg <= cfg_data;
                cbc_pkg::CFG_RAM_SIZE: ram_size_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rom_bank_next   = rom_bank_reg;
        mapped_next     = mapped_reg;
        ram_mode_next   = ram_mode_reg;
        ram_enable_next = ram_enable_reg;
        ram_bank_next   = ram_bank_reg;
        rom_cand        = rom_bank_reg;
        do_remap        = 1'b0;
        refused         = 1'b0;
        if (func == cbc_pkg::FUNC_WRITE)
        begin
            unique case (address[15:13])
                cbc_pkg::REGION_RAM_EN:
                begin
                    if (ram_size_reg != cbc_pkg::RAM_SIZE_NONE)
                    begin
                        ram_enable_next = (write_data[3:0] == cbc_pkg::ENABLE_KEY);
                    end
                end
                cbc_pkg::REGION_ROM_LOW:
                begin
                    rom_cand = {rom_bank_reg[6:5], write_data[4:0]};
                    do_remap = 1'b1;
                end
                cbc_pkg::REGION_ROM_HIGH:
                begin
                    if (!ram_mode_reg)
                    begin
                        rom_cand = {write_data[1:0], rom_bank_reg[4:0]};
                        do_remap = 1'b1;
                    end
                    else
                    begin
                        ram_bank_next = write_data[1:0];
                    end
                end
                cbc_pkg::REGION_MODE:
                begin
                    if (ram_size_reg != cbc_pkg::RAM_SIZE_NONE)
                    begin
                        ram_mode_next = write_data[0];
                    end
                end
                default: ;
            endcase
        end
        remap = cbc_pkg::cbc_remap(rom_cand, rom_size_reg);
        if (do_remap)
        begin
            rom_bank_next = rom_cand;
            refused       = remap.refused;
            if (!remap.refused)
            begin
                mapped_next = remap.bank;
            end
        end
    end

    // RAM slot check uses the bank register as it stands before this access
    assign offset     = address[12:0];
    assign in_ram     = (address[15:13] == cbc_pkg::REGION_RAM);
    assign bank_limit = (ram_size_reg == cbc_pkg::RAM_SIZE_32K) ? BANKS_BIG : 3'd1;
    assign byte_limit = (ram_size_reg == cbc_pkg::RAM_SIZE_2K) ? LIM_SMALL : LIM_FULL;
    assign slot_ok    = in_ram
                        && (ram_size_reg != cbc_pkg::RAM_SIZE_NONE)
                        && ram_enable_reg
                        && ({1'b0, ram_bank_reg} < bank_limit)
                        && ({1'b0, offset} < byte_limit);
    assign idx_wide   = (IDX_W+2)'(ram_bank_reg) * (IDX_W+2)'(RAM_BANK_BYTES)
                        + (IDX_W+2)'(offset);
    assign ram_index  = idx_wide[IDX_W-1:0];

    assign ram_req.wr_en = commit && slot_ok && (func == cbc_pkg::FUNC_WRITE);
    assign ram_req.rd_en = commit && slot_ok && (func == cbc_pkg::FUNC_READ);

    assign result.mapped_rom_bank   = mapped_next;
    assign result.selected_ram_bank = ram_bank_next;
    assign result.ram_on            = ram_enable_next;
    assign result.switch_refused    = refused;
    assign result.rd_hit            = slot_ok && (func == cbc_pkg::FUNC_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg   <= cbc_pkg::ROM_BANK_RESET;
            mapped_reg     <= cbc_pkg::ROM_BANK_RESET;
            ram_mode_reg   <= 1'b0;
            ram_enable_reg <= 1'b0;
            ram_bank_reg   <= '0;
        end
        else if (commit)
        begin
            rom_bank_reg   <= rom_bank_next;
            mapped_reg     <= mapped_next;
            ram_mode_reg   <= ram_mode_next;
            ram_enable_reg <= ram_enable_next;
            ram_bank_reg   <= ram_bank_next;
        end
    end

endmodule
